/* rtl/ffbt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffbt_pkg;
  localparam logic [1:0] StAlloc  = 2'd0;
  localparam logic [1:0] StNoFit  = 2'd1;
  localparam logic [1:0] StFreed  = 2'd2;
  localparam logic       ActAlloc = 1'b0;
  localparam logic       ActFree  = 1'b1;

  typedef enum logic [2:0] {
    CmdIdle, CmdStart, CmdStep, CmdTake, CmdSplitNew, CmdFound, CmdMerge
  } ffbt_cmd_e;

  // datapath status back to the controller, for the header at the walk position
  typedef struct packed {
    logic fits;       // free and large enough
    logic split;      // leftover big enough for a new block
    logic nb_in;      // split remainder inside arena
    logic last;       // next position beyond arena
    logic match;      // position is the block being freed
  } ffbt_stat_t;
endpackage
`default_nettype wire

/* rtl/ffbt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffbt_datapath import ffbt_pkg::*; #(
  parameter int ArenaWords  = 1024,
  parameter int HeaderWords = 3,
  localparam int Aw = $clog2(ArenaWords),
  localparam int Pw = Aw + 1
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ffbt_cmd_e  cmd_i,
  input  wire logic [9:0] req_i,
  input  wire logic [9:0] addr_i,
  output ffbt_stat_t      stat_o,
  output logic [9:0]      gaddr_o,
  output logic            init_done_o
);
  localparam int Sw = (Pw + 2 > 11) ? Pw + 2 : 11;
  localparam int Ew = Pw + 1;
  localparam logic [Sw-1:0] Arena    = Sw'(ArenaWords);
  localparam logic [Sw-1:0] Hdr      = Sw'(HeaderWords);
  localparam logic [Pw-1:0] InitSize = Pw'(ArenaWords - HeaderWords);

  // entry: used, size
  logic [Ew-1:0] mem_q [ArenaWords];
  logic [Ew-1:0] rdat_q;
  logic [Aw-1:0] raddr;
  logic          we;
  logic [Aw-1:0] waddr;
  logic [Ew-1:0] wdat;

  logic [Pw-1:0] init_q;
  logic          init_done;
  logic [Pw-1:0] pos_q, prev_q, cur_q, psz_q, csz_q;
  logic          pused_q, has_prev_q, nxt_in_q;
  logic [9:0]    req_q, addr_q;

  logic          r_used;
  logic [Pw-1:0] r_size;
  logic [Sw-1:0] pos_w, size_w, req_w, hdr_end_w, nxt_w, nb_w, left_w, split_sz_w;
  logic [Sw-1:0] tail_w, head_w;
  logic          pfree, nfree;

  assign r_used     = rdat_q[Ew-1];
  assign r_size     = rdat_q[Pw-1:0];
  assign pos_w      = Sw'(pos_q);
  assign size_w     = Sw'(r_size);
  assign req_w      = Sw'(req_q);
  assign hdr_end_w  = pos_w + Hdr;
  assign nxt_w      = hdr_end_w + size_w;
  assign left_w     = size_w - req_w;
  assign nb_w       = Sw'(cur_q) + Hdr + req_w;
  assign split_sz_w = Sw'(csz_q) - req_w - Hdr;
  assign init_done  = (init_q == Pw'(ArenaWords));

  assign stat_o.fits  = !r_used && (size_w >= req_w);
  assign stat_o.split = left_w >= Hdr;
  assign stat_o.nb_in = (hdr_end_w + req_w) < Arena;
  assign stat_o.last  = nxt_w >= Arena;
  assign stat_o.match = hdr_end_w == Sw'(addr_q);

  assign gaddr_o     = hdr_end_w[9:0];
  assign init_done_o = init_done;

  // rdat_q holds the next header during the merge cycle
  assign pfree  = has_prev_q && !pused_q;
  assign nfree  = nxt_in_q && !r_used;
  assign tail_w = nfree ? (Sw'(csz_q) + Hdr + size_w) : Sw'(csz_q);
  assign head_w = pfree ? (Sw'(psz_q) + Hdr + tail_w) : tail_w;

  always_comb begin
    case (cmd_i)
      CmdStart:          raddr = '0;
      CmdStep, CmdFound: raddr = nxt_w[Aw-1:0];
      default:           raddr = pos_q[Aw-1:0];
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = cur_q[Aw-1:0]; wdat = '0;
    if (!init_done) begin
      we = 1'b1; waddr = init_q[Aw-1:0];
      wdat = (init_q == '0) ? {1'b0, InitSize} : '0;
    end else begin
      case (cmd_i)
        CmdTake: begin
          we = 1'b1; waddr = pos_q[Aw-1:0];
          wdat = {1'b1, stat_o.split ? req_w[Pw-1:0] : r_size};
        end
        CmdSplitNew: begin
          we = 1'b1; waddr = nb_w[Aw-1:0];
          wdat = {1'b0, split_sz_w[Pw-1:0]};
        end
        CmdMerge: begin
          we = 1'b1; waddr = pfree ? prev_q[Aw-1:0] : cur_q[Aw-1:0];
          wdat = {1'b0, head_w[Pw-1:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdat;
    rdat_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0; pos_q <= '0; prev_q <= '0; cur_q <= '0; psz_q <= '0; csz_q <= '0;
      pused_q <= 1'b1; has_prev_q <= 1'b0; nxt_in_q <= 1'b0;
      req_q <= '0; addr_q <= '0;
    end else begin
      if (!init_done) init_q <= init_q + Pw'(1);
      case (cmd_i)
        CmdStart: begin
          pos_q <= '0; has_prev_q <= 1'b0; pused_q <= 1'b1;
          req_q <= req_i; addr_q <= addr_i;
        end
        CmdStep: begin
          prev_q <= pos_q; psz_q <= r_size; pused_q <= r_used; has_prev_q <= 1'b1;
          pos_q <= nxt_w[Pw-1:0];
        end
        CmdTake, CmdFound: begin
          cur_q <= pos_q; csz_q <= r_size; nxt_in_q <= !stat_o.last;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ffbt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffbt_ctrl import ffbt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       act_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [9:0]      granted_addr_o,
  output ffbt_cmd_e       cmd_o,
  input  wire ffbt_stat_t stat_i,
  input  wire logic [9:0] gaddr_i,
  input  wire logic       init_done_i
);
  typedef enum logic [1:0] {SIdle, SEval, SSplit, SMerge} state_e;
  state_e state_q;
  logic   act_q;
  logic   accept;

  assign in_ready_o = init_done_i && state_q == SIdle && !out_valid_o;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = CmdIdle;
    case (state_q)
      SIdle: if (accept) cmd_o = CmdStart;
      SEval: begin
        if (act_q == ActAlloc) begin
          if (stat_i.fits) cmd_o = CmdTake;
          else if (!stat_i.last) cmd_o = CmdStep;
        end else begin
          if (stat_i.match) cmd_o = CmdFound;
          else if (!stat_i.last) cmd_o = CmdStep;
        end
      end
      SSplit: cmd_o = CmdSplitNew;
      SMerge: cmd_o = CmdMerge;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; out_valid_o <= 1'b0; act_q <= ActAlloc;
      status_o <= StAlloc; granted_addr_o <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        SIdle: if (accept) begin
          act_q <= act_i; state_q <= SEval;
        end
        SEval: begin
          case (cmd_o)
            CmdTake: begin
              status_o <= StAlloc; granted_addr_o <= gaddr_i;
              if (stat_i.split && stat_i.nb_in) state_q <= SSplit;
              else begin
                out_valid_o <= 1'b1; state_q <= SIdle;
              end
            end
            CmdFound: state_q <= SMerge;
            CmdStep: ;
            default: begin
              // walked past the last block
              status_o <= (act_q == ActAlloc) ? StNoFit : StFreed;
              granted_addr_o <= '0; out_valid_o <= 1'b1; state_q <= SIdle;
            end
          endcase
        end
        SSplit: begin
          out_valid_o <= 1'b1; state_q <= SIdle;
        end
        SMerge: begin
          status_o <= StFreed; granted_addr_o <= '0;
          out_valid_o <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(granted_addr_o)) else $error("result dropped or changed");
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StAlloc |-> granted_addr_o == '0) else $error("addr");
  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StAlloc || status_o == StNoFit || status_o == StFreed))
    else $error("bad status");
`endif
endmodule
`default_nettype wire

/* rtl/first_fit_boundary_tag_allocator_unit.sv */
// After an input transfer the unit reads the headers in turn from word 0, 1 to
//   ARENA_WORDS / HEADER_WORDS of them, until the result is known; an allocate that
//   splits a block passes through a split state and a free that finds its block
//   through a merge state first. Only one item is in flight; the next input transfer
//   is taken at the earliest in the cycle after the result transfer.
// Reset: asynchronous, active low; a clearing pass over all ARENA_WORDS words
//   rebuilds the arena as one free block before the first transfer.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_boundary_tag_allocator_unit import ffbt_pkg::*; #(
  parameter int ARENA_WORDS  = 1024,
  parameter int HEADER_WORDS = 3
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       action_i,
  input  wire logic [9:0] request_size_i,
  input  wire logic [9:0] block_addr_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [9:0]      granted_addr_o
);
  ffbt_cmd_e  cmd;
  ffbt_stat_t stat;
  logic [9:0] gaddr;
  logic       init_done;

  ffbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .act_i(action_i),
    .out_valid_o, .out_ready_i, .status_o, .granted_addr_o,
    .cmd_o(cmd), .stat_i(stat), .gaddr_i(gaddr), .init_done_i(init_done)
  );

  ffbt_datapath #(.ArenaWords(ARENA_WORDS), .HeaderWords(HEADER_WORDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(request_size_i),
    .addr_i(block_addr_i), .stat_o(stat), .gaddr_o(gaddr), .init_done_o(init_done)
  );
endmodule
`default_nettype wire
